// ===== rtl/bls_pkg.sv =====
package bls_pkg;

  localparam int NUM_LANES  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_RANGE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_LEVEL = 3'd5;

  localparam logic [15:0] DEF_CENTER     = 16'h6000;
  localparam logic [14:0] DEF_RANGE      = 15'h0100;
  localparam logic [15:0] FALLOFF_SPAN   = 16'h0080;
  localparam logic [7:0]  CLAMP_MAX      = 8'h80;
  localparam logic [7:0]  FLAT_LOW_LIMIT = 8'h60;
  localparam logic [7:0]  FLAT_LOW_RED   = 8'h60;
  localparam logic [31:0] BLUE_FIXED     = 32'h0080_0000;
  localparam logic [31:0] TEX_BIT        = 32'h0200_0000;
  localparam logic [31:0] CODE_TRI       = 32'h3400_0000;
  localparam logic [31:0] CODE_QUAD      = 32'h3C00_0000;
  localparam logic [31:0] TEX_HIGH       = 32'hFF00_0000;

  localparam logic [3:0] PW_LIT_TRI   = 4'd9;
  localparam logic [3:0] PW_FLAT_TRI  = 4'd7;
  localparam logic [3:0] PW_LIT_QUAD  = 4'd12;
  localparam logic [3:0] PW_FLAT_QUAD = 4'd9;

  // Light parameters in effect, shared by all lanes.
  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic [14:0]        r;
    logic signed [15:0] rlo;
    logic signed [15:0] lo_x;
    logic signed [15:0] hi_x;
    logic signed [15:0] lo_y;
    logic signed [15:0] hi_y;
    logic signed [15:0] lo_z;
    logic signed [15:0] hi_z;
    logic [7:0]         amb;
  } light_t;

  typedef struct packed {
    logic        lit;
    logic [31:0] color_a;
    logic [31:0] color_b;
    logic [31:0] color_c;
    logic [31:0] color_d;
    logic [3:0]  packet_words;
  } result_t;

endpackage

// ===== rtl/box_light_vertex_shading.sv =====
// Shades one triangle or quad per request against a box light. Four lanes test and
// shade the vertices side by side and a merge stage builds the gouraud or flat words.
// A new primitive is taken every cycle while in_stall is low. It passes an input
// register in each lane, then the two chained falloff multiplies, each followed
// by a register. A stall on the result side backs up through the pipeline only once
// every stage holds a request. Configuration writes are always ready and must only
// be issued while no primitive is in flight.
module box_light_vertex_shading
  import bls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic [47:0]           in_vertex_a,
  input  logic [47:0]           in_vertex_b,
  input  logic [47:0]           in_vertex_c,
  input  logic [47:0]           in_vertex_d,
  input  logic [31:0]           in_texture_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_lit,
  output logic [31:0]           out_color_a,
  output logic [31:0]           out_color_b,
  output logic [31:0]           out_color_c,
  output logic [31:0]           out_color_d,
  output logic [3:0]            out_packet_words,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        light_enable_r;
  logic [15:0] center_x_r, center_y_r, center_z_r;
  logic [14:0] light_range_r;
  logic [7:0]  ambient_level_r;

  logic [15:0] cx, cy, cz, rw;
  logic [14:0] r;
  logic [7:0]  amb;
  logic [23:0] flat;
  light_t      light;

  logic v1_r, v2_r, out_valid_r;
  logic adv1, adv2, adv_out;
  logic mode1_r, mode2_r;
  logic [7:0] tex1_r, tex2_r;

  logic [NUM_LANES-1:0][47:0] vtx;
  logic [NUM_LANES-1:0][7:0]  shade;
  logic [NUM_LANES-1:0]       hit;
  result_t                    res_nxt, res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_enable_r  <= 1'b0;
      center_x_r      <= DEF_CENTER;
      center_y_r      <= DEF_CENTER;
      center_z_r      <= DEF_CENTER;
      light_range_r   <= DEF_RANGE;
      ambient_level_r <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LIGHT_ENABLE:  light_enable_r  <= cfg_data[0];
        CFG_CENTER_X:      center_x_r      <= cfg_data;
        CFG_CENTER_Y:      center_y_r      <= cfg_data;
        CFG_CENTER_Z:      center_z_r      <= cfg_data;
        CFG_LIGHT_RANGE:   light_range_r   <= cfg_data[14:0];
        CFG_AMBIENT_LEVEL: ambient_level_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // With the light disabled the fixed default light applies and the flat colour is black.
  assign cx  = light_enable_r ? center_x_r : DEF_CENTER;
  assign cy  = light_enable_r ? center_y_r : DEF_CENTER;
  assign cz  = light_enable_r ? center_z_r : DEF_CENTER;
  assign r   = light_enable_r ? light_range_r : DEF_RANGE;
  assign amb = light_enable_r ? ambient_level_r : 8'd0;
  assign rw  = {1'b0, r};

  always_comb begin
    if (!light_enable_r) begin
      flat = 24'd0;
    end else if (ambient_level_r < FLAT_LOW_LIMIT) begin
      flat = {FLAT_LOW_RED, ambient_level_r, ambient_level_r};
    end else begin
      flat = {ambient_level_r, ambient_level_r, ambient_level_r};
    end
  end

  // Box bounds wrap to 16 bits, so a wrapped box may contain nothing.
  always_comb begin
    light.cx   = $signed(cx);
    light.cy   = $signed(cy);
    light.cz   = $signed(cz);
    light.r    = r;
    light.rlo  = $signed(rw - FALLOFF_SPAN);
    light.lo_x = $signed(cx - rw);
    light.hi_x = $signed(cx + rw);
    light.lo_y = $signed(cy - rw);
    light.hi_y = $signed(cy + rw);
    light.lo_z = $signed(cz - rw);
    light.hi_z = $signed(cz + rw);
    light.amb  = amb;
  end

  // Each stage moves on when it is empty or the stage after it moves on.
  assign adv_out  = !out_valid_r || !out_stall;
  assign adv2     = !v2_r || adv_out;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv_out) begin
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      mode1_r <= in_mode;
      tex1_r  <= in_texture_word[31:24];
    end
    if (adv2) begin
      mode2_r <= mode1_r;
      tex2_r  <= tex1_r;
    end
    if (adv_out) begin
      res_r <= res_nxt;
    end
  end

  assign vtx = {in_vertex_d, in_vertex_c, in_vertex_b, in_vertex_a};

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    bls_lane u_lane (
      .clk    (clk),
      .en1    (adv1),
      .en2    (adv2),
      .vertex (vtx[i]),
      .light  (light),
      .shade  (shade[i]),
      .hit    (hit[i])
    );
  end

  bls_merge u_merge (
    .mode   (mode2_r),
    .tex_hi (tex2_r),
    .flat   (flat),
    .shade  (shade),
    .hit    (hit),
    .res    (res_nxt)
  );

  assign out_valid        = out_valid_r;
  assign out_lit          = res_r.lit;
  assign out_color_a      = res_r.color_a;
  assign out_color_b      = res_r.color_b;
  assign out_color_c      = res_r.color_c;
  assign out_color_d      = res_r.color_d;
  assign out_packet_words = res_r.packet_words;

  // The input side only stalls when every pipeline stage holds a request.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline had room");

  // A flat result carries its colour in the first word only.
  a_flat_words: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_lit) |->
      (out_color_b == 32'd0 && out_color_c == 32'd0 && out_color_d == 32'd0))
    else $error("flat result with nonzero vertex colours");

  // Packet length follows the lit flag.
  a_packet_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_lit) |->
      (out_packet_words == PW_LIT_TRI || out_packet_words == PW_LIT_QUAD))
    else $error("lit result with a flat packet length");

endmodule

// ===== rtl/bls_lane.sv =====
module bls_lane
  import bls_pkg::*;
(
  input  logic        clk,
  input  logic        en1,
  input  logic        en2,
  input  logic [47:0] vertex,
  input  light_t      light,
  output logic [7:0]  shade,
  output logic        hit
);

  typedef struct packed {
    logic       kill;
    logic       scale;
    logic [6:0] factor;
  } fringe_t;

  function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
    logic signed [16:0] d;
    d = {a[15], a} - {b[15], b};
    return d[16] ? 16'(-d) : d[15:0];
  endfunction

  // Classifies one distance against the falloff fringe of the box.
  function automatic fringe_t classify(input logic [15:0] d, input light_t lt);
    fringe_t f;
    logic [15:0] rem;
    rem = {1'b0, lt.r} - d;
    f.kill   = d > {1'b0, lt.r};
    f.scale  = !f.kill && (lt.rlo[15] || (d > $unsigned(lt.rlo)));
    f.factor = rem[6:0];
    return f;
  endfunction

  function automatic logic [7:0] scale_axis(input logic [7:0] a, input fringe_t f);
    logic [14:0] prod;
    logic [7:0]  res;
    prod = {7'd0, a} * {8'd0, f.factor};
    if (f.kill) begin
      res = 8'd0;
    end else if (f.scale) begin
      res = prod[14:7];
    end else begin
      res = a;
    end
    return res;
  endfunction

  logic signed [15:0] vx, vy, vz;
  logic [15:0]        dx, dy, dz, x_rem;
  logic               x_near, x_fringe, in_box;
  logic [7:0]         ax;

  logic [7:0] ax_r, az_r, az_nxt, ay;
  fringe_t    fz_r, fy_r, fy2_r;
  logic       inside_r, inside2_r;
  logic [8:0] sum;

  assign vx = $signed(vertex[15:0]);
  assign vy = $signed(vertex[31:16]);
  assign vz = $signed(vertex[47:32]);

  assign dx = abs_diff(vx, light.cx);
  assign dy = abs_diff(vy, light.cy);
  assign dz = abs_diff(vz, light.cz);

  assign in_box = (light.lo_x < vx) && (vx < light.hi_x) &&
                  (light.lo_y < vy) && (vy < light.hi_y) &&
                  (light.lo_z < vz) && (vz < light.hi_z);

  // Along x the full level holds inside the inner box and ramps down in the fringe.
  assign x_rem    = {1'b0, light.r} - dx;
  assign x_near   = dx < {1'b0, light.r};
  assign x_fringe = light.rlo[15] || (dx >= $unsigned(light.rlo));
  assign ax       = x_near ? (x_fringe ? x_rem[7:0] : CLAMP_MAX) : 8'd0;

  assign az_nxt = scale_axis(ax_r, fz_r);

  always_ff @(posedge clk) begin
    if (en1) begin
      ax_r     <= ax;
      fz_r     <= classify(dz, light);
      fy_r     <= classify(dy, light);
      inside_r <= in_box;
    end
    if (en2) begin
      az_r      <= az_nxt;
      fy2_r     <= fy_r;
      inside2_r <= inside_r;
    end
  end

  assign ay    = scale_axis(az_r, fy2_r);
  assign sum   = {1'b0, ay} + {1'b0, light.amb};
  assign shade = (sum > {1'b0, CLAMP_MAX}) ? CLAMP_MAX : sum[7:0];
  assign hit   = inside2_r;

endmodule

// ===== rtl/bls_merge.sv =====
module bls_merge
  import bls_pkg::*;
(
  input  logic                      mode,
  input  logic [7:0]                tex_hi,
  input  logic [23:0]               flat,
  input  logic [NUM_LANES-1:0][7:0] shade,
  input  logic [NUM_LANES-1:0]      hit,
  output result_t                   res
);

  logic [31:0] tex;
  logic [31:0] cb;
  logic        lit;

  assign tex = {tex_hi, 24'd0};
  // The fourth lane only counts for quads.
  assign lit = hit[0] | hit[1] | hit[2] | (mode & hit[3]);
  assign cb  = (tex & TEX_BIT) | (mode ? CODE_QUAD : CODE_TRI) | BLUE_FIXED;

  always_comb begin
    res = '0;
    res.lit = lit;
    if (lit) begin
      res.color_a = cb | {16'd0, shade[0], shade[0]};
      res.color_b = cb | {16'd0, shade[1], shade[1]};
      res.color_c = cb | {16'd0, shade[2], shade[2]};
      res.color_d = mode ? (cb | {16'd0, shade[3], shade[3]}) : 32'd0;
      res.packet_words = mode ? PW_LIT_QUAD : PW_LIT_TRI;
    end else begin
      res.color_a = (tex & TEX_HIGH) | {8'd0, flat};
      res.packet_words = mode ? PW_FLAT_QUAD : PW_FLAT_TRI;
    end
  end

endmodule

// ===== tb/sv/box_light_vertex_shading_tb.sv =====
module box_light_vertex_shading_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bls_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 212;

  // Indexes past the register list; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam logic [47:0] V_MID = {DEF_CENTER, DEF_CENTER, DEF_CENTER};
  localparam logic [47:0] V_FAR = 48'h7000_7000_7000;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic             mode;
    logic [3:0][47:0] vert;
    logic [31:0]      tex;
  } prim_t;

  function automatic int wrap16(int x);
    return {{16{x[15]}}, x[15:0]};
  endfunction

  function automatic int mag(int x);
    return (x < 0) ? -x : x;
  endfunction

  class shade_board;
    bit          light_on;
    logic [15:0] cen_x;
    logic [15:0] cen_y;
    logic [15:0] cen_z;
    logic [14:0] half_size;
    logic [7:0]  amb_level;
    result_t     pending_colors[$];
    int          mismatches;

    function new();
      light_on   = 1'b0;
      cen_x      = DEF_CENTER;
      cen_y      = DEF_CENTER;
      cen_z      = DEF_CENTER;
      half_size  = DEF_RANGE;
      amb_level  = 8'h00;
      mismatches = 0;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LIGHT_ENABLE:  light_on = data[0];
        CFG_CENTER_X:      cen_x = data;
        CFG_CENTER_Y:      cen_y = data;
        CFG_CENTER_Z:      cen_z = data;
        CFG_LIGHT_RANGE:   half_size = data[14:0];
        CFG_AMBIENT_LEVEL: amb_level = data[7:0];
        default: ;
      endcase
    endfunction

    // Attenuation along the second and third axes: scaled by (r - d) / 128 in the fringe.
    function int axis_fade(int a, int d, int r, int rlo);
      if (r < d)
        return 0;
      if (rlo < d)
        return (a * (r - d)) >>> 7;
      return a;
    endfunction

    function result_t predict_colors(prim_t p);
      int          ctr [3];
      int          lo [3];
      int          hi [3];
      int          v [4][3];
      logic [31:0] col [4];
      int          r;
      int          rlo;
      int          amb;
      int          nv;
      int          a;
      int          d;
      logic [31:0] flat;
      logic [31:0] base;
      logic [7:0]  c;
      bit          lit;
      bit          in_box;
      result_t     res;
      if (light_on) begin
        ctr[0] = wrap16(cen_x);
        ctr[1] = wrap16(cen_y);
        ctr[2] = wrap16(cen_z);
        r = int'(half_size);
        amb = int'(amb_level);
        if (amb_level < FLAT_LOW_LIMIT)
          flat = {8'h00, FLAT_LOW_RED, amb_level, amb_level};
        else
          flat = {8'h00, amb_level, amb_level, amb_level};
      end else begin
        ctr[0] = int'(DEF_CENTER);
        ctr[1] = int'(DEF_CENTER);
        ctr[2] = int'(DEF_CENTER);
        r = int'(DEF_RANGE);
        amb = 0;
        flat = 32'h0;
      end
      rlo = r - int'(FALLOFF_SPAN);
      nv = p.mode ? 4 : 3;
      for (int k = 0; k < 3; k++) begin
        lo[k] = wrap16(ctr[k] - r);
        hi[k] = wrap16(ctr[k] + r);
      end
      for (int i = 0; i < 4; i++)
        for (int k = 0; k < 3; k++)
          v[i][k] = wrap16(p.vert[i][16*k +: 16]);
      lit = 1'b0;
      for (int i = 0; i < nv; i++) begin
        in_box = 1'b1;
        for (int k = 0; k < 3; k++)
          if (!(lo[k] < v[i][k] && v[i][k] < hi[k]))
            in_box = 1'b0;
        if (in_box)
          lit = 1'b1;
      end
      for (int i = 0; i < 4; i++)
        col[i] = 32'h0;
      res = '0;
      if (lit) begin
        base = (p.tex & TEX_BIT) | (p.mode ? CODE_QUAD : CODE_TRI);
        for (int i = 0; i < nv; i++) begin
          a = 0;
          d = mag(v[i][0] - ctr[0]);
          if (d < r) begin
            a = int'(CLAMP_MAX);
            if (d >= rlo)
              a = r - d;
          end
          a = axis_fade(a, mag(v[i][2] - ctr[2]), r, rlo);
          a = axis_fade(a, mag(v[i][1] - ctr[1]), r, rlo);
          a = a + amb;
          if (a > int'(CLAMP_MAX))
            a = int'(CLAMP_MAX);
          c = a[7:0];
          col[i] = base | BLUE_FIXED | {16'h0000, c, c};
        end
        res.packet_words = p.mode ? PW_LIT_QUAD : PW_LIT_TRI;
      end else begin
        col[0] = (p.tex & TEX_HIGH) | flat;
        res.packet_words = p.mode ? PW_FLAT_QUAD : PW_FLAT_TRI;
      end
      res.lit = lit;
      res.color_a = col[0];
      res.color_b = col[1];
      res.color_c = col[2];
      res.color_d = col[3];
      return res;
    endfunction

    function void note_primitive(prim_t p);
      pending_colors.push_back(predict_colors(p));
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch: %s", what);
    endtask

    task check_colors(result_t got);
      result_t want;
      if (pending_colors.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, color_a %h", got.color_a));
        return;
      end
      want = pending_colors.pop_front();
      if (got.lit !== want.lit)
        report_mismatch($sformatf("lit got %b want %b", got.lit, want.lit));
      if (got.color_a !== want.color_a)
        report_mismatch($sformatf("color_a got %h want %h", got.color_a, want.color_a));
      if (got.color_b !== want.color_b)
        report_mismatch($sformatf("color_b got %h want %h", got.color_b, want.color_b));
      if (got.color_c !== want.color_c)
        report_mismatch($sformatf("color_c got %h want %h", got.color_c, want.color_c));
      if (got.color_d !== want.color_d)
        report_mismatch($sformatf("color_d got %h want %h", got.color_d, want.color_d));
      if (got.packet_words !== want.packet_words)
        report_mismatch($sformatf("packet_words got %0d want %0d",
                                  got.packet_words, want.packet_words));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = 1'b0;
  logic [47:0]           in_vertex_a = '0;
  logic [47:0]           in_vertex_b = '0;
  logic [47:0]           in_vertex_c = '0;
  logic [47:0]           in_vertex_d = '0;
  logic [31:0]           in_texture_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_lit;
  logic [31:0]           out_color_a;
  logic [31:0]           out_color_b;
  logic [31:0]           out_color_c;
  logic [31:0]           out_color_d;
  logic [3:0]            out_packet_words;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  shade_board  board = new();

  box_light_vertex_shading u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_vertex_a      (in_vertex_a),
    .in_vertex_b      (in_vertex_b),
    .in_vertex_c      (in_vertex_c),
    .in_vertex_d      (in_vertex_d),
    .in_texture_word  (in_texture_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_lit          (out_lit),
    .out_color_a      (out_color_a),
    .out_color_b      (out_color_b),
    .out_color_c      (out_color_c),
    .out_color_d      (out_color_d),
    .out_packet_words (out_packet_words),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    prim_t   seen;
    result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        seen.mode = in_mode;
        seen.vert = {in_vertex_d, in_vertex_c, in_vertex_b, in_vertex_a};
        seen.tex  = in_texture_word;
        board.note_primitive(seen);
      end
      if (out_valid && !out_stall) begin
        got.lit          = out_lit;
        got.color_a      = out_color_a;
        got.color_b      = out_color_b;
        got.color_c      = out_color_c;
        got.color_d      = out_color_d;
        got.packet_words = out_packet_words;
        board.check_colors(got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [47:0] vtx(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic prim_t mk_prim(logic mode, logic [47:0] a, logic [47:0] b,
                                    logic [47:0] c, logic [47:0] d, logic [31:0] tex);
    prim_t p;
    p.mode = mode;
    p.vert = {d, c, b, a};
    p.tex  = tex;
    return p;
  endfunction

  function automatic logic [15:0] near_axis(int c, int r);
    int span;
    int off;
    int t;
    span = r + 64;
    off = $urandom_range(2 * span);
    t = c + off - span;
    return t[15:0];
  endfunction

  function automatic logic [15:0] pick_center();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10)
      return 16'h8000;
    if (sel < 20)
      return 16'h7FFF;
    return 16'($urandom);
  endfunction

  // Most vertices land around the light box so that the inside test and the
  // falloff fringe are reached; the rest are raw noise.
  function automatic prim_t random_primitive();
    prim_t       p;
    int          ctr [3];
    int          r;
    bit          noise;
    logic [63:0] w;
    if (board.light_on) begin
      ctr[0] = wrap16(board.cen_x);
      ctr[1] = wrap16(board.cen_y);
      ctr[2] = wrap16(board.cen_z);
      r = int'(board.half_size);
    end else begin
      ctr[0] = int'(DEF_CENTER);
      ctr[1] = int'(DEF_CENTER);
      ctr[2] = int'(DEF_CENTER);
      r = int'(DEF_RANGE);
    end
    p.mode = 1'($urandom_range(1));
    p.tex = $urandom;
    noise = ($urandom_range(99) < 10);
    for (int i = 0; i < 4; i++) begin
      if (noise || $urandom_range(99) < 30) begin
        w = {$urandom, $urandom};
        p.vert[i] = w[47:0];
      end else begin
        for (int k = 0; k < 3; k++)
          p.vert[i][16*k +: 16] = near_axis(ctr[k], r);
      end
    end
    return p;
  endfunction

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 53; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      default:       begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  task automatic send_primitive(prim_t p);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= p.mode;
    in_vertex_a     <= p.vert[0];
    in_vertex_b     <= p.vert[1];
    in_vertex_c     <= p.vert[2];
    in_vertex_d     <= p.vert[3];
    in_texture_word <= p.tex;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  // Stop sending and let every request in flight come out.
  task automatic drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_colors.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_light_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    board.apply_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_light(logic [15:0] en, logic [15:0] cx, logic [15:0] cy,
                            logic [15:0] cz, logic [15:0] rng, logic [15:0] amb);
    drain_pipe();
    write_light_reg(CFG_LIGHT_ENABLE, en);
    write_light_reg(CFG_CENTER_X, cx);
    write_light_reg(CFG_CENTER_Y, cy);
    write_light_reg(CFG_CENTER_Z, cz);
    write_light_reg(CFG_LIGHT_RANGE, rng);
    write_light_reg(CFG_AMBIENT_LEVEL, amb);
  endtask

  task automatic random_light(int phase);
    logic [15:0] en;
    logic [15:0] rng;
    logic [15:0] amb;
    int          sel;
    en = 16'($urandom);
    en[0] = (phase != 5);
    rng = 16'($urandom);
    sel = $urandom_range(99);
    if (sel < 50)
      rng[14:0] = 15'($urandom_range(300));
    else if (sel < 85)
      rng[14:0] = 15'($urandom_range(4000));
    else
      rng[14:0] = 15'($urandom_range(32767));
    if (phase == 2)
      rng[14:0] = 15'h7FFF;
    if (phase == 6)
      rng[14:0] = 15'h0000;
    amb = 16'($urandom);
    if (phase == 1)
      amb[7:0] = 8'h00;
    if (phase == 3)
      amb[7:0] = 8'hFF;
    load_light(en, pick_center(), pick_center(), pick_center(), rng, amb);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_NONE);

    // Default light after reset: box around 0x6000 with half size 0x100.
    send_primitive(mk_prim(1'b0, 48'h0, 48'h0, 48'h0, 48'h0, 32'h0000_0000));
    send_primitive(mk_prim(1'b1, '1, '1, '1, '1, 32'hFFFF_FFFF));
    send_primitive(mk_prim(1'b0, V_MID, 48'h0, 48'h0, 48'h0, 32'h0200_0000));
    send_primitive(mk_prim(1'b1, vtx(16'h60C0, 16'h6000, 16'h6000),
                           vtx(16'h5F40, 16'h6040, 16'h60A0), 48'h0, V_MID, 32'hFDFF_FFFF));
    send_primitive(mk_prim(1'b0, vtx(16'h6100, 16'h6000, 16'h6000),
                           vtx(16'h5F00, 16'h6000, 16'h6000),
                           vtx(16'h60FF, 16'h5F01, 16'h60FF), 48'h0, 32'h1234_5678));
    // Only the fourth vertex inside: ignored for a triangle, lights a quad.
    send_primitive(mk_prim(1'b0, 48'h0, 48'h0, 48'h0, V_MID, 32'hFF00_0000));
    send_primitive(mk_prim(1'b1, 48'h0, 48'h0, 48'h0, V_MID, 32'hA5A5_5A5A));

    // Ambient just below the flat threshold, range with bit 15 set in the write.
    load_light(16'hFFFF, 16'h0100, 16'hFF00, 16'h0000, 16'h80C8, 16'hFF5F);
    send_primitive(mk_prim(1'b0, vtx(16'h0100, 16'hFF00, 16'h0000),
                           vtx(16'h0150, 16'hFF40, 16'h0020), 48'h0, 48'h0, 32'h0));
    send_primitive(mk_prim(1'b1, V_FAR, V_FAR, V_FAR, V_FAR, 32'h8000_0000));
    load_light(16'h0001, 16'h0100, 16'hFF00, 16'h0000, 16'h00C8, 16'h0060);
    send_primitive(mk_prim(1'b0, V_FAR, V_FAR, V_FAR, V_FAR, 32'hFFFF_FFFF));

    // Zero range leaves an empty box under strict compares.
    load_light(16'h0001, 16'h0100, 16'hFF00, 16'h0000, 16'h0000, 16'h0010);
    send_primitive(mk_prim(1'b0, vtx(16'h0100, 16'hFF00, 16'h0000), 48'h0, 48'h0, 48'h0,
                           32'h0));

    // Range below the fringe width: falloff covers the whole box.
    load_light(16'h0001, 16'h0100, 16'hFF00, 16'h0000, 16'h0032, 16'h0000);
    send_primitive(mk_prim(1'b0, vtx(16'h010A, 16'hFF00, 16'h0000), 48'h0, 48'h0, 48'h0,
                           32'h0200_0000));
    send_primitive(mk_prim(1'b1, vtx(16'h0131, 16'hFEF0, 16'h0031),
                           vtx(16'h0100, 16'hFF00, 16'h0000), 48'h0, V_FAR, 32'h0));

    // Bounds that wrap past the 16-bit limits.
    load_light(16'h0001, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0064, 16'h0000);
    send_primitive(mk_prim(1'b0, vtx(16'h7FFF, 16'h7FFF, 16'h7FFF), 48'h0, 48'h0, 48'h0,
                           32'h0));
    load_light(16'h0001, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h00FF);
    send_primitive(mk_prim(1'b0, 48'h0, 48'h0, 48'h0, 48'h0, 32'h5A00_0000));

    load_light(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
    write_light_reg(CFG_SPARE_A, 16'hFFFF);
    write_light_reg(CFG_SPARE_B, 16'h0000);
    send_primitive(mk_prim(1'b0, vtx(16'h7FFE, 16'h8002, 16'h0064),
                           vtx(16'h8000, 16'h0000, 16'h0000),
                           vtx(16'h7FFF, 16'h0000, 16'h0000), 48'h0, 32'h0200_0000));
    send_primitive(mk_prim(1'b1, vtx(16'h8001, 16'h7FFE, 16'h0000), 48'h0,
                           vtx(16'h0001, 16'h0002, 16'h0003), '1, 32'hFFFF_FFFF));

    // Disabled again: registers hold odd values but the default light applies.
    load_light(16'h0000, 16'h1234, 16'h5678, 16'h9ABC, 16'h7FFF, 16'h00FF);
    send_primitive(mk_prim(1'b0, V_MID, V_FAR, V_FAR, 48'h0, 32'h0200_0000));
    send_primitive(mk_prim(1'b1, V_FAR, V_FAR, V_FAR, V_FAR, 32'hFFFF_FFFF));

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_idling(idle_mode_e'(phase % 4));
      random_light(phase);
      repeat (ITEMS_PER_PHASE) send_primitive(random_primitive());
    end

    drain_pipe();
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (board.mismatches == 0 && board.pending_colors.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
